>>> hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion on the project clock clk_i and reset rst_ni.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Types and constants shared by the ellipse rasterizer modules.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Width of the wrapping decision variable and of the emitted points.
  localparam int DEC_W   = 56;
  localparam int POINT_W = 15;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // Operand pairs for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_A2_1M2B,
    MUL_B2_X1,
    MUL_A2_YM1,
    MUL_SQ_2X1,
    MUL_B2_P,
    MUL_SQ_YM2,
    MUL_A2_P,
    MUL_A2_B2,
    MUL_B2_2X3,
    MUL_A2_2MY,
    MUL_A2_3MY
  } mul_sel_e;

  // What is done with the registered product.
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_A2,
    ACC_B2,
    ACC_D_START,
    ACC_LHS,
    ACC_D_LOAD,
    ACC_D_ADD,
    ACC_D_SUB,
    ACC_D_ADD4,
    ACC_R1_Y,
    ACC_R2_X
  } acc_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    acc_e     acc;
    logic     snap_sign;
    logic     x_inc;
    logic     yh_dec2;
    logic [1:0] quad;
    logic     empty;
  } dp_cmd_t;

  typedef struct packed {
    logic r1_hold;
    logic yh_pos;
  } dp_status_t;

endpackage

>>> hdl/mer_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse walk registers, one shared multiplier and the point mirroring.
// ----------------------------------------------------------------------------
module mer_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  mer_pkg::dp_cmd_t            cmd_i,
  output mer_pkg::dp_status_t         status_o,
  input  logic [COORD_BITS-1:0]       corner_a_x_i,
  input  logic [COORD_BITS-1:0]       corner_a_y_i,
  input  logic [COORD_BITS-1:0]       corner_b_x_i,
  input  logic [COORD_BITS-1:0]       corner_b_y_i,
  output logic signed [mer_pkg::POINT_W-1:0] point_x_o,
  output logic signed [mer_pkg::POINT_W-1:0] point_y_o
);
  import mer_pkg::*;

  localparam int CX_W   = COORD_BITS + 1;
  localparam int A2_W   = 2 * COORD_BITS;
  localparam int X_W    = COORD_BITS + 1;
  localparam int YH_W   = COORD_BITS + 2;
  localparam int OP_W   = 2 * COORD_BITS + 4;
  localparam int PROD_W = 2 * OP_W;
  localparam int PT_W   = COORD_BITS + 4;

  localparam logic signed [OP_W-1:0] K1 = OP_W'(1);
  localparam logic signed [OP_W-1:0] K2 = OP_W'(2);
  localparam logic signed [OP_W-1:0] K3 = OP_W'(3);
  localparam logic signed [YH_W-1:0] YH_TWO  = YH_W'(2);
  localparam logic signed [YH_W-1:0] YH_ZERO = YH_W'(0);

  logic [CX_W-1:0]              cx_q, cx_d, cy_q, cy_d;
  logic [COORD_BITS-1:0]        ax_len_q, ax_len_d, by_len_q, by_len_d;
  logic [A2_W-1:0]              a2_q, a2_d, b2_q, b2_d;
  logic [X_W-1:0]               x_q, x_d;
  logic signed [YH_W-1:0]       yh_q, yh_d;
  logic [DEC_W-1:0]             d_q, d_d, lhs_q, lhs_d;
  logic signed [DEC_W-1:0]      p_q, p_d;
  logic                         sign_q, sign_d;

  logic signed [OP_W-1:0]       a2_e, b2_e, ax_e, by_e, x_e, yh_e, p_e;
  logic signed [OP_W-1:0]       op_a, op_b;
  logic signed [PROD_W-1:0]     prod;
  logic [DEC_W-1:0]             p_u;
  logic signed [PT_W-1:0]       cx_p, cy_p, x2_p, yh_p, px, py;

  assign a2_e = signed'(OP_W'(a2_q));
  assign b2_e = signed'(OP_W'(b2_q));
  assign ax_e = signed'(OP_W'(ax_len_q));
  assign by_e = signed'(OP_W'(by_len_q));
  assign x_e  = signed'(OP_W'(x_q));
  assign yh_e = OP_W'(yh_q);
  assign p_e  = signed'(p_q[OP_W-1:0]);
  assign p_u  = p_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_NONE:    begin op_a = '0;   op_b = '0;                       end
      MUL_AA:      begin op_a = ax_e; op_b = ax_e;                     end
      MUL_BB:      begin op_a = by_e; op_b = by_e;                     end
      MUL_A2_1M2B: begin op_a = a2_e; op_b = K1 - (by_e <<< 1);        end
      MUL_B2_X1:   begin op_a = b2_e; op_b = x_e + K1;                 end
      MUL_A2_YM1:  begin op_a = a2_e; op_b = yh_e - K1;                end
      MUL_SQ_2X1:  begin op_a = (x_e <<< 1) + K1; op_b = (x_e <<< 1) + K1; end
      MUL_B2_P:    begin op_a = b2_e; op_b = p_e;                      end
      MUL_SQ_YM2:  begin op_a = yh_e - K2; op_b = yh_e - K2;           end
      MUL_A2_P:    begin op_a = a2_e; op_b = p_e;                      end
      MUL_A2_B2:   begin op_a = a2_e; op_b = b2_e;                     end
      MUL_B2_2X3:  begin op_a = b2_e; op_b = (x_e <<< 1) + K3;         end
      MUL_A2_2MY:  begin op_a = a2_e; op_b = K2 - yh_e;                end
      MUL_A2_3MY:  begin op_a = a2_e; op_b = K3 - yh_e;                end
      default:     begin op_a = '0;   op_b = '0;                       end
    endcase
  end

  assign prod = op_a * op_b;
  assign p_d  = DEC_W'(prod);

  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    ax_len_d = ax_len_q;
    by_len_d = by_len_q;
    a2_d     = a2_q;
    b2_d     = b2_q;
    x_d      = x_q;
    yh_d     = yh_q;
    d_d      = d_q;
    lhs_d    = lhs_q;
    sign_d   = sign_q;

    if (cmd_i.load) begin
      cx_d     = CX_W'(corner_a_x_i) + CX_W'(corner_b_x_i);
      cy_d     = CX_W'(corner_a_y_i) + CX_W'(corner_b_y_i);
      ax_len_d = (corner_a_x_i > corner_b_x_i) ? corner_a_x_i - corner_b_x_i
                                                : corner_b_x_i - corner_a_x_i;
      by_len_d = (corner_a_y_i > corner_b_y_i) ? corner_a_y_i - corner_b_y_i
                                                : corner_b_y_i - corner_a_y_i;
      x_d      = '0;
      yh_d     = signed'(YH_W'(by_len_d));
    end

    if (cmd_i.snap_sign) begin
      sign_d = d_q[DEC_W-1];
    end

    unique case (cmd_i.acc)
      ACC_NONE:    ;
      ACC_A2:      a2_d  = p_u[A2_W-1:0];
      ACC_B2:      b2_d  = p_u[A2_W-1:0];
      ACC_D_START: d_d   = DEC_W'({b2_q, 2'b00}) + p_u;
      ACC_LHS:     lhs_d = p_u;
      ACC_D_LOAD:  d_d   = p_u;
      ACC_D_ADD:   d_d   = d_q + p_u;
      ACC_D_SUB:   d_d   = d_q - p_u;
      ACC_D_ADD4:  d_d   = d_q + (p_u << 2);
      ACC_R1_Y: begin
        if (!sign_q) begin
          d_d  = d_q + (p_u << 2);
          yh_d = yh_q - YH_TWO;
        end
      end
      ACC_R2_X: begin
        if (sign_q) begin
          d_d = d_q + (p_u << 3);
          x_d = x_q + X_W'(1);
        end
      end
      default: ;
    endcase

    if (cmd_i.x_inc) begin
      x_d = x_q + X_W'(1);
    end
    if (cmd_i.yh_dec2) begin
      yh_d = yh_q - YH_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    ax_len_q <= ax_len_d;
    by_len_q <= by_len_d;
    a2_q     <= a2_d;
    b2_q     <= b2_d;
    x_q      <= x_d;
    yh_q     <= yh_d;
    d_q      <= d_d;
    lhs_q    <= lhs_d;
    sign_q   <= sign_d;
    p_q      <= p_d;
  end

  // Region 1 holds while Yh >= 2 and 2*B^2*(x+1) < A^2*(Yh-1); the product
  // register holds the right-hand side when this is sampled.
  assign status_o.r1_hold = (yh_q >= YH_TWO) && ((lhs_q << 1) < p_u);
  assign status_o.yh_pos  = (yh_q > YH_ZERO);

  assign cx_p = signed'(PT_W'(cx_q));
  assign cy_p = signed'(PT_W'(cy_q));
  assign x2_p = signed'(PT_W'({x_q, 1'b0}));
  assign yh_p = PT_W'(yh_q);

  // Quadrant order: (+x,+y), (+x,-y), (-x,-y), (-x,+y).
  always_comb begin
    px = cmd_i.quad[1] ? (cx_p - x2_p) : (cx_p + x2_p);
    py = (cmd_i.quad[1] ^ cmd_i.quad[0]) ? (cy_p - yh_p) : (cy_p + yh_p);
  end

  assign point_x_o = cmd_i.empty ? '0 : POINT_W'(px);
  assign point_y_o = cmd_i.empty ? '0 : POINT_W'(py);

endmodule

>>> hdl/mer_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the ellipse walk: handshakes, phase and multiplier schedule.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                empty_res_o,
  output logic                ellipse_done_o,
  output logic                last_of_run_o,
  output mer_pkg::dp_cmd_t    cmd_o,
  input  mer_pkg::dp_status_t status_i
);
  import mer_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ST_SQA, S_ST_SQB, S_ST_DS, S_ST_DS2,
    S_CHK1, S_CHK2, S_CHK3,
    S_R2E1, S_R2E2, S_R2E3, S_R2E4, S_R2E5, S_R2E6,
    S_R1_M1, S_R1_M2, S_R1_M3,
    S_R2_M1, S_R2_M2, S_R2_M3, S_R2_FIN,
    S_EMIT, S_EMPTY
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_DONE
  } phase_e;

  localparam logic [1:0] QUAD_LAST = 2'd3;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] quad_q, quad_d;
  logic       in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    quad_d        = quad_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc     = ACC_NONE;
    cmd_o.quad    = quad_q;
    cmd_o.empty   = (state_q == S_EMPTY);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_e'(operation_i) == OP_START) begin
            cmd_o.load = 1'b1;
            state_d    = S_ST_SQA;
          end else begin
            cmd_o.snap_sign = 1'b1;
            unique case (phase_q)
              PH_R1:   state_d = S_R1_M1;
              PH_R2:   state_d = S_R2_M1;
              default: state_d = S_EMPTY;
            endcase
          end
        end
      end
      S_ST_SQA: begin
        cmd_o.mul_sel = MUL_AA;
        state_d       = S_ST_SQB;
      end
      S_ST_SQB: begin
        cmd_o.mul_sel = MUL_BB;
        cmd_o.acc     = ACC_A2;
        state_d       = S_ST_DS;
      end
      S_ST_DS: begin
        cmd_o.mul_sel = MUL_A2_1M2B;
        cmd_o.acc     = ACC_B2;
        state_d       = S_ST_DS2;
      end
      S_ST_DS2: begin
        cmd_o.acc = ACC_D_START;
        state_d   = S_CHK1;
      end
      S_CHK1: begin
        cmd_o.mul_sel = MUL_B2_X1;
        state_d       = S_CHK2;
      end
      S_CHK2: begin
        cmd_o.mul_sel = MUL_A2_YM1;
        cmd_o.acc     = ACC_LHS;
        state_d       = S_CHK3;
      end
      S_CHK3: begin
        if (status_i.r1_hold) begin
          phase_d = PH_R1;
          state_d = S_EMIT;
        end else begin
          state_d = S_R2E1;
        end
      end
      S_R2E1: begin
        cmd_o.mul_sel = MUL_SQ_2X1;
        state_d       = S_R2E2;
      end
      S_R2E2: begin
        cmd_o.mul_sel = MUL_B2_P;
        state_d       = S_R2E3;
      end
      S_R2E3: begin
        cmd_o.mul_sel = MUL_SQ_YM2;
        cmd_o.acc     = ACC_D_LOAD;
        state_d       = S_R2E4;
      end
      S_R2E4: begin
        cmd_o.mul_sel = MUL_A2_P;
        state_d       = S_R2E5;
      end
      S_R2E5: begin
        cmd_o.mul_sel = MUL_A2_B2;
        cmd_o.acc     = ACC_D_ADD;
        state_d       = S_R2E6;
      end
      S_R2E6: begin
        cmd_o.acc = ACC_D_SUB;
        phase_d   = status_i.yh_pos ? PH_R2 : PH_DONE;
        state_d   = S_EMIT;
      end
      S_R1_M1: begin
        cmd_o.mul_sel = MUL_B2_2X3;
        state_d       = S_R1_M2;
      end
      S_R1_M2: begin
        cmd_o.mul_sel = MUL_A2_2MY;
        cmd_o.acc     = ACC_D_ADD4;
        state_d       = S_R1_M3;
      end
      S_R1_M3: begin
        cmd_o.acc   = ACC_R1_Y;
        cmd_o.x_inc = 1'b1;
        state_d     = S_CHK1;
      end
      S_R2_M1: begin
        cmd_o.mul_sel = MUL_A2_3MY;
        state_d       = S_R2_M2;
      end
      S_R2_M2: begin
        cmd_o.mul_sel = MUL_B2_X1;
        cmd_o.acc     = ACC_D_ADD4;
        state_d       = S_R2_M3;
      end
      S_R2_M3: begin
        cmd_o.acc     = ACC_R2_X;
        cmd_o.yh_dec2 = 1'b1;
        state_d       = S_R2_FIN;
      end
      S_R2_FIN: begin
        phase_d = status_i.yh_pos ? PH_R2 : PH_DONE;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          quad_d = quad_q + 2'd1;
          if (quad_q == QUAD_LAST) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      quad_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      quad_q  <= quad_d;
    end
  end

  assign out_valid_o    = (state_q == S_EMIT) || (state_q == S_EMPTY);
  assign empty_res_o    = (state_q == S_EMPTY);
  assign ellipse_done_o = (state_q == S_EMIT) && (phase_q == PH_DONE);
  assign last_of_run_o  = (state_q == S_EMPTY) ||
                          ((state_q == S_EMIT) && (quad_q == QUAD_LAST));

endmodule

>>> hdl/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse walker that emits four mirrored points per position.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i / in_ready_o) takes one request at a time.
// A start request (operation_i = 0) latches two corners and produces the four
// points of the top position; an advance request (operation_i = 1) moves one
// position along the quadrant and produces its four points. An advance before
// any start, or after the final position, produces one empty result.
// Results leave on out_valid_o / out_ready_i, one point per handshake, with
// last_of_run_o marking the final result of a request.
// Flow: a request is taken only while the block is idle. A start runs the
// shared multiplier schedule for the squares, the initial decision value and
// the region check, plus the region-2 setup when it falls straight into
// region 2; a region-1 advance runs its update and the region check (plus
// the setup on the switch into region 2); a region-2 advance runs its update.
// The four results then go out one per cycle while the receiver is ready.
// A request with points needs two to ten products from the single multiplier.
// A stalled receiver holds the current result in place and the block simply
// waits; no request is taken until the last result has been accepted.
// Reset returns the block to idle with no ellipse loaded.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [COORD_BITS-1:0]         corner_a_x_i,
  input  logic [COORD_BITS-1:0]         corner_a_y_i,
  input  logic [COORD_BITS-1:0]         corner_b_x_i,
  input  logic [COORD_BITS-1:0]         corner_b_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [mer_pkg::POINT_W-1:0] point_x_o,
  output logic signed [mer_pkg::POINT_W-1:0] point_y_o,
  output logic                          empty_res_o,
  output logic                          ellipse_done_o,
  output logic                          last_of_run_o
);
  import mer_pkg::*;

  // Command and status between the sequencer and the arithmetic.
  dp_cmd_t    cmd;
  dp_status_t status;

  mer_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .empty_res_o    (empty_res_o),
    .ellipse_done_o (ellipse_done_o),
    .last_of_run_o  (last_of_run_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  // The datapath keeps the decision variable exactly 16 times the real
  // midpoint value, so every update is an integer multiply and add.
  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .corner_a_x_i (corner_a_x_i),
    .corner_a_y_i (corner_a_y_i),
    .corner_b_x_i (corner_b_x_i),
    .corner_b_y_i (corner_b_y_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o)
  );

endmodule

>>> hdl/mer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_checker
// Port-level assertions for the ellipse rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mer_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [mer_pkg::POINT_W-1:0]  point_x_o,
  input logic signed [mer_pkg::POINT_W-1:0]  point_y_o,
  input logic                                empty_res_o,
  input logic                                ellipse_done_o,
  input logic                                last_of_run_o
);
  import mer_pkg::*;

  `ASSERT_STD(a_out_valid_holds, (out_valid_o && !out_ready_i |=> out_valid_o),
              "result dropped while stalled")
  `ASSERT_STD(a_out_payload_holds,
              (out_valid_o && !out_ready_i |=> $stable(point_x_o) && $stable(point_y_o)
               && $stable(last_of_run_o)),
              "result changed while stalled")
  `ASSERT_STD(a_no_take_while_busy, (out_valid_o |-> !in_ready_o),
              "request taken while results pending")
  `ASSERT_STD(a_empty_shape,
              (out_valid_o && empty_res_o |-> last_of_run_o && !ellipse_done_o
               && point_x_o == '0 && point_y_o == '0),
              "malformed empty result")
  `ASSERT_STD(a_run_ends, (out_valid_o && out_ready_i && last_of_run_o |=> !out_valid_o),
              "result after end of run")

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .point_x_o      (point_x_o),
  .point_y_o      (point_y_o),
  .empty_res_o    (empty_res_o),
  .ellipse_done_o (ellipse_done_o),
  .last_of_run_o  (last_of_run_o)
);
